// File: rtl/core/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types and constants for the pixel format converter: format codes,
// conversion routes and the control bundle that travels down the pipeline.
// ----------------------------------------------------------------------------
package pfc_pkg;

	// Widths of the pixel word and of a format code.
	localparam int PixelWidth = 32;
	localparam int FmtWidth   = 4;
	localparam int CfgIdxWidth = 1;

	// Format codes, as written into the format registers.
	localparam logic [FmtWidth-1:0] FMT_A8       = 4'd0;
	localparam logic [FmtWidth-1:0] FMT_RGB565   = 4'd1;
	localparam logic [FmtWidth-1:0] FMT_BGR565   = 4'd2;
	localparam logic [FmtWidth-1:0] FMT_RGBA4444 = 4'd3;
	localparam logic [FmtWidth-1:0] FMT_BGRA4444 = 4'd4;
	localparam logic [FmtWidth-1:0] FMT_RGBA5551 = 4'd5;
	localparam logic [FmtWidth-1:0] FMT_BGRA5551 = 4'd6;
	localparam logic [FmtWidth-1:0] FMT_RGB888   = 4'd7;
	localparam logic [FmtWidth-1:0] FMT_RGBA8888 = 4'd8;
	localparam logic [FmtWidth-1:0] FMT_BGRA8888 = 4'd9;

	// Configuration register indexes.
	localparam logic [CfgIdxWidth-1:0] REG_SOURCE_FORMAT = 1'd0;
	localparam logic [CfgIdxWidth-1:0] REG_TARGET_FORMAT = 1'd1;

	// Division of a nibble product (at most 225) by 15 as a multiply by
	// 137/2048; the error stays below one unit over that range.
	localparam logic [7:0] Recip15  = 8'd137;
	localparam int         DivShift = 11;
	localparam int         QuotWidth = 15;

	// How a transaction is converted.
	typedef enum logic [2:0] {
		ROUTE_NONE,
		ROUTE_PASS,
		ROUTE_DIRECT,
		ROUTE_PREMUL_RGB,
		ROUTE_PREMUL_BGR
	} route_t;

	// Control bundle carried alongside the pixel data.
	typedef struct packed {
		logic                valid;
		route_t              route;
		logic [FmtWidth-1:0] src_fmt;
		logic [FmtWidth-1:0] dst_fmt;
	} pfc_ctl_t;

endpackage

// File: rtl/core/pfc_if.sv
// ----------------------------------------------------------------------------
// pfc_src_if / pfc_dst_if
// Valid/ready channels that carry source pixels into the converter and
// converted pixels out of it.
// ----------------------------------------------------------------------------
interface pfc_src_if import pfc_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [PixelWidth-1:0] source_pixel;

	modport source (output valid, output source_pixel, input ready);
	modport sink   (input valid, input source_pixel, output ready);
endinterface

interface pfc_dst_if import pfc_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [PixelWidth-1:0] target_pixel;
	logic                  supported;

	modport source (output valid, output target_pixel, output supported, input ready);
	modport sink   (input valid, input target_pixel, input supported, output ready);
endinterface

// File: rtl/core/pfc_decode.sv
// ----------------------------------------------------------------------------
// pfc_decode
// First pipeline stage: captures the source pixel and decides from the format
// pair which conversion route the transaction takes.
// ----------------------------------------------------------------------------
module pfc_decode import pfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [PixelWidth-1:0] in_pixel,
	input  logic [FmtWidth-1:0]   src_fmt,
	input  logic [FmtWidth-1:0]   dst_fmt,
	output pfc_ctl_t              ctl_s1,
	output logic [PixelWidth-1:0] pixel_s1
);

	logic                valid_s1;
	route_t              route_s1;
	logic [FmtWidth-1:0] src_fmt_s1;
	logic [FmtWidth-1:0] dst_fmt_s1;
	route_t              route_d;

	// Route selection for the format pair.
	always_comb begin
		route_d = ROUTE_NONE;
		if (src_fmt == dst_fmt) begin
			route_d = ROUTE_PASS;
		end else begin
			unique case (src_fmt)
				FMT_A8: begin
					if (dst_fmt >= FMT_RGB565 && dst_fmt <= FMT_BGRA8888)
						route_d = ROUTE_DIRECT;
				end
				FMT_RGB565, FMT_BGR565: begin
					if (dst_fmt <= FMT_BGRA8888)
						route_d = ROUTE_DIRECT;
				end
				FMT_RGBA4444: begin
					unique case (dst_fmt)
						FMT_A8, FMT_BGRA4444: route_d = ROUTE_DIRECT;
						FMT_RGB565:           route_d = ROUTE_PREMUL_RGB;
						FMT_BGR565:           route_d = ROUTE_PREMUL_BGR;
						default:              route_d = ROUTE_NONE;
					endcase
				end
				default: route_d = ROUTE_NONE;
			endcase
		end
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_valid;
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			pixel_s1   <= in_pixel;
			route_s1   <= route_d;
			src_fmt_s1 <= src_fmt;
			dst_fmt_s1 <= dst_fmt;
		end
	end

	assign ctl_s1 = '{valid: valid_s1, route: route_s1, src_fmt: src_fmt_s1,
		dst_fmt: dst_fmt_s1};

endmodule

// File: rtl/core/pfc_expand.sv
// ----------------------------------------------------------------------------
// pfc_expand
// Second pipeline stage: forms the converted word for every route that is a
// plain rearrangement of bits, and the colour-times-alpha products for the
// premultiplied 565 outputs.
// ----------------------------------------------------------------------------
module pfc_expand import pfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  pfc_ctl_t              ctl_s1,
	input  logic [PixelWidth-1:0] pixel_s1,
	output pfc_ctl_t              ctl_s2,
	output logic [PixelWidth-1:0] direct_s2,
	output logic [7:0]            prod_r_s2,
	output logic [7:0]            prod_g_s2,
	output logic [7:0]            prod_b_s2
);

	logic                  valid_s2;
	route_t                route_s2;
	logic [FmtWidth-1:0]   src_fmt_s2;
	logic [FmtWidth-1:0]   dst_fmt_s2;
	logic [PixelWidth-1:0] direct_d;
	logic [PixelWidth-1:0] hi_first;
	logic [PixelWidth-1:0] lo_first;
	logic [15:0]           s;
	logic [7:0]            b;
	logic                  rgb;

	assign s   = pixel_s1[15:0];
	assign b   = pixel_s1[7:0];
	assign rgb = (ctl_s1.src_fmt == FMT_RGB565);

	// 565 to 32-bit layouts: upper field in byte 0, or lower field in byte 0.
	assign hi_first = {8'hFF, s[4:0], 3'b000, s[10:5], 2'b00, s[15:11], 3'b000};
	assign lo_first = {8'hFF, s[15:11], 3'b000, s[10:5], 2'b00, s[4:0], 3'b000};

	// Bit rearrangement for the direct routes.
	always_comb begin
		direct_d = '0;
		if (ctl_s1.route == ROUTE_PASS) begin
			direct_d = pixel_s1;
		end else if (ctl_s1.src_fmt == FMT_A8) begin
			case (ctl_s1.dst_fmt)
				FMT_RGB565, FMT_BGR565:
					direct_d = {16'h0, b[7:3], b[7:2], b[7:3]};
				FMT_RGBA4444, FMT_BGRA4444:
					direct_d = {16'h0, 12'hFFF, b[7:4]};
				FMT_RGBA5551, FMT_BGRA5551:
					direct_d = {16'h0, 15'h7FFF, b[7]};
				FMT_RGB888:
					direct_d = {8'h00, b, b, b};
				FMT_RGBA8888, FMT_BGRA8888:
					direct_d = {b, 24'hFFFFFF};
				default:
					direct_d = '0;
			endcase
		end else if (ctl_s1.src_fmt == FMT_RGBA4444) begin
			case (ctl_s1.dst_fmt)
				FMT_A8:       direct_d = {24'h0, s[3:0], 4'h0};
				FMT_BGRA4444: direct_d = {16'h0, s[7:4], s[11:8], s[15:12], s[3:0]};
				default:      direct_d = '0;
			endcase
		end else begin
			// RGB565 and BGR565 sources.
			case (ctl_s1.dst_fmt)
				FMT_A8:
					direct_d = 32'h0000_00FF;
				FMT_RGB565, FMT_BGR565:
					direct_d = {16'h0, s[4:0], s[10:5], s[15:11]};
				FMT_RGBA4444:
					direct_d = rgb ? {16'h0, s[15:12], s[10:7], s[4:1], 4'hF}
						: {16'h0, s[4:1], s[10:7], s[15:12], 4'hF};
				FMT_BGRA4444:
					direct_d = rgb ? {16'h0, s[4:1], s[10:7], s[15:12], 4'hF}
						: {16'h0, s[15:12], s[10:7], s[4:1], 4'hF};
				FMT_RGBA5551:
					direct_d = rgb ? {16'h0, s[15:6], s[4:0], 1'b1}
						: {16'h0, s[4:0], s[10:6], s[15:11], 1'b1};
				FMT_BGRA5551:
					direct_d = rgb ? {16'h0, s[4:0], s[10:6], s[15:11], 1'b1}
						: {16'h0, s[15:6], s[4:0], 1'b1};
				FMT_RGB888:
					direct_d = rgb ? {8'h00, hi_first[23:0]} : {8'h00, lo_first[23:0]};
				FMT_RGBA8888:
					direct_d = rgb ? hi_first : lo_first;
				FMT_BGRA8888:
					direct_d = rgb ? lo_first : hi_first;
				default:
					direct_d = '0;
			endcase
		end
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en)
			valid_s2 <= ctl_s1.valid;
	end

	// Stage payload: each colour nibble times the alpha nibble.
	always_ff @(posedge clk) begin
		if (en) begin
			route_s2   <= ctl_s1.route;
			src_fmt_s2 <= ctl_s1.src_fmt;
			dst_fmt_s2 <= ctl_s1.dst_fmt;
			direct_s2  <= direct_d;
			prod_r_s2  <= 8'(s[15:12]) * 8'(s[3:0]);
			prod_g_s2  <= 8'(s[11:8]) * 8'(s[3:0]);
			prod_b_s2  <= 8'(s[7:4]) * 8'(s[3:0]);
		end
	end

	assign ctl_s2 = '{valid: valid_s2, route: route_s2, src_fmt: src_fmt_s2,
		dst_fmt: dst_fmt_s2};

endmodule

// File: rtl/core/pfc_assemble.sv
// ----------------------------------------------------------------------------
// pfc_assemble
// Third pipeline stage and output register: divides the alpha products by
// fifteen, packs the premultiplied 565 word and selects the final result.
// ----------------------------------------------------------------------------
module pfc_assemble import pfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  pfc_ctl_t              ctl_s2,
	input  logic [PixelWidth-1:0] direct_s2,
	input  logic [7:0]            prod_r_s2,
	input  logic [7:0]            prod_g_s2,
	input  logic [7:0]            prod_b_s2,
	output logic                  valid_s3,
	output logic [PixelWidth-1:0] pixel_s3,
	output logic                  supported_s3
);

	logic [QuotWidth-1:0]  scaled_r;
	logic [QuotWidth-1:0]  scaled_g;
	logic [QuotWidth-1:0]  scaled_b;
	logic [3:0]            quot_r;
	logic [3:0]            quot_g;
	logic [3:0]            quot_b;
	logic [PixelWidth-1:0] pixel_d;
	logic                  supported_d;

	// Truncating division by fifteen through the reciprocal.
	assign scaled_r = QuotWidth'(prod_r_s2) * QuotWidth'(Recip15);
	assign scaled_g = QuotWidth'(prod_g_s2) * QuotWidth'(Recip15);
	assign scaled_b = QuotWidth'(prod_b_s2) * QuotWidth'(Recip15);
	assign quot_r   = scaled_r[DivShift +: 4];
	assign quot_g   = scaled_g[DivShift +: 4];
	assign quot_b   = scaled_b[DivShift +: 4];

	// Result selection by route.
	always_comb begin
		pixel_d     = '0;
		supported_d = 1'b1;
		unique case (ctl_s2.route)
			ROUTE_PASS, ROUTE_DIRECT:
				pixel_d = direct_s2;
			ROUTE_PREMUL_RGB:
				pixel_d = {16'h0, quot_r, 1'b0, quot_g, 2'b00, quot_b, 1'b0};
			ROUTE_PREMUL_BGR:
				pixel_d = {16'h0, quot_b, 1'b0, quot_g, 2'b00, quot_r, 1'b0};
			default: begin
				pixel_d     = '0;
				supported_d = 1'b0;
			end
		endcase
	end

	// Valid bit of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (en)
			valid_s3 <= ctl_s2.valid;
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (en) begin
			pixel_s3     <= pixel_d;
			supported_s3 <= supported_d;
		end
	end

endmodule

// File: rtl/core/pixel_format_converter.sv
// ----------------------------------------------------------------------------
// pixel_format_converter
// An accepted source transaction passes the decode, expand and assemble registers in turn.
// Throughput: one pixel per cycle; the three stages advance together and
// hold while the result in the output register waits to be taken.
// Reset: asynchronous; clears the stage valid bits and sets both formats to A8.
// Converts a pixel word between ten packed formats selected by two registers.
// ----------------------------------------------------------------------------
module pixel_format_converter import pfc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	pfc_src_if.sink                src,
	pfc_dst_if.source              dst,
	input  logic                   cfg_wr_en,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [FmtWidth-1:0]    cfg_wdata
);

	logic [FmtWidth-1:0]   source_format_q;
	logic [FmtWidth-1:0]   target_format_q;
	logic                  en;
	pfc_ctl_t              ctl_s1;
	pfc_ctl_t              ctl_s2;
	logic [PixelWidth-1:0] pixel_s1;
	logic [PixelWidth-1:0] direct_s2;
	logic [7:0]            prod_r_s2;
	logic [7:0]            prod_g_s2;
	logic [7:0]            prod_b_s2;
	logic                  valid_s3;
	logic [PixelWidth-1:0] pixel_s3;
	logic                  supported_s3;

	// Format registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= FMT_A8;
			target_format_q <= FMT_A8;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SOURCE_FORMAT: source_format_q <= cfg_wdata;
				REG_TARGET_FORMAT: target_format_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves unless a finished result is held.
	assign en        = !valid_s3 || dst.ready;
	assign src.ready = en;

	pfc_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (src.valid),
		.in_pixel (src.source_pixel),
		.src_fmt  (source_format_q),
		.dst_fmt  (target_format_q),
		.ctl_s1   (ctl_s1),
		.pixel_s1 (pixel_s1)
	);

	pfc_expand u_expand (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_s1    (ctl_s1),
		.pixel_s1  (pixel_s1),
		.ctl_s2    (ctl_s2),
		.direct_s2 (direct_s2),
		.prod_r_s2 (prod_r_s2),
		.prod_g_s2 (prod_g_s2),
		.prod_b_s2 (prod_b_s2)
	);

	pfc_assemble u_assemble (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.ctl_s2       (ctl_s2),
		.direct_s2    (direct_s2),
		.prod_r_s2    (prod_r_s2),
		.prod_g_s2    (prod_g_s2),
		.prod_b_s2    (prod_b_s2),
		.valid_s3     (valid_s3),
		.pixel_s3     (pixel_s3),
		.supported_s3 (supported_s3)
	);

	// Output channel.
	assign dst.valid        = valid_s3;
	assign dst.target_pixel = pixel_s3;
	assign dst.supported    = supported_s3;

	// A source transaction is always taken while no result is held.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s3 |-> src.ready)
		else $error("source not ready although the output register is empty");

	// An accepted transaction occupies the first stage on the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		src.valid && src.ready |=> ctl_s1.valid)
		else $error("accepted transaction missing from the first stage");

	// An unsupported format pair always yields a zero pixel.
	a_unsupported_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dst.valid && !dst.supported |-> dst.target_pixel == '0)
		else $error("unsupported result carries a non-zero pixel");

	// A held result keeps the pipeline behind it frozen.
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !dst.ready |=> $stable(ctl_s2) && $stable(direct_s2))
		else $error("second stage changed while the output was stalled");

endmodule
